[rtl/core/ptd_pkg.sv]
// shared types and constants for the periodic task dispatcher
`default_nettype none

package ptd_pkg;

  // default number of task slots
  localparam int NUM_TASKS_DEF = 8;

  // field widths
  localparam int SLOT_W      = 3;
  localparam int TIME_W      = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // operation codes carried in tuser
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_CREATE = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } ptd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic create;      // write the slot named by the input word
    logic scan_clear;  // start a scan at slot zero
    logic step;        // process the current slot and advance
    logic flush;       // hand the held due slot out as the last word
  } ptd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic due;         // current slot is valid with countdown zero
    logic held_valid;  // a due slot waits to learn whether it is the last
    logic out_free;    // output register can take a word this cycle
    logic scan_end;    // current slot is the final one
  } ptd_status_t;

endpackage

`default_nettype wire

[rtl/core/periodic_task_dispatcher_core.sv]
// Periodic task dispatcher: top level joining controller and datapath.
//
// Input channel s_axis: tuser selects the operation (0 tick, 1 create).
// A create word writes period and start delay into the named slot and
// marks it valid; a slot at or above NUM_TASKS is ignored. A create
// word gives no output word.
// A tick word starts a scan of all slots, one slot per cycle unless
// stalled, lowest index first. Each valid slot with countdown zero is
// due: its countdown reloads with period minus one, every other valid
// slot counts down. Output channel m_axis carries one word per due
// slot; tlast marks the final due slot of the tick. A tick with no due
// slot gives no word. After a tick is taken s_axis_tready stays low
// through the scan of every slot and the flush, so the next word is
// taken once the controller is back in idle, later if the output stalls.
// The first word of a tick is valid once the second due slot is found or
// at the flush. When m_axis_tready is low the scan pauses at the next
// due slot while a word already waits; nothing is dropped.
// Reset clears all valid marks, so no task exists after reset.
`default_nettype none

module periodic_task_dispatcher_core #(
  parameter int NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // slot [2:0], period [18:3], start_delay [34:19], zero [39:35]
  input  wire logic [ptd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // op
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // due_slot [2:0], zero [7:3]
  output logic [ptd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast
);

  import ptd_pkg::*;

  ptd_cmd_t          cmd;
  ptd_status_t       status;
  logic [SLOT_W-1:0] in_slot;
  logic [TIME_W-1:0] in_period;
  logic [TIME_W-1:0] in_start_delay;
  logic [SLOT_W-1:0] out_slot;

  // unpack the input word
  assign in_slot        = s_axis_tdata[SLOT_W-1:0];
  assign in_period      = s_axis_tdata[SLOT_W+TIME_W-1:SLOT_W];
  assign in_start_delay = s_axis_tdata[SLOT_W+2*TIME_W-1:SLOT_W+TIME_W];

  // controller
  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  // datapath
  ptd_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_slot        (in_slot),
    .in_period      (in_period),
    .in_start_delay (in_start_delay),
    .out_ready      (m_axis_tready),
    .status         (status),
    .out_valid      (m_axis_tvalid),
    .out_slot       (out_slot),
    .out_last       (m_axis_tlast)
  );

  // pack the output word
  assign m_axis_tdata = OUT_TDATA_W'(out_slot);

endmodule

`default_nettype wire

[rtl/core/ptd_ctrl.sv]
// controller state machine for the periodic task dispatcher
`default_nettype none

module ptd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_op,
  input  wire ptd_pkg::ptd_status_t status,
  output logic                     in_ready,
  output ptd_pkg::ptd_cmd_t        cmd
);

  import ptd_pkg::*;

  ptd_state_t state;
  ptd_state_t state_next;
  logic       step_ok;
  logic       flush_ok;

  // a due slot can only be taken when the held one has somewhere to go
  assign step_ok  = !(status.due && status.held_valid && !status.out_free);
  assign flush_ok = !status.held_valid || status.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (in_op == OP_TICK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_ok && status.scan_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.create     = in_valid && (in_op == OP_CREATE);
        cmd.scan_clear = in_valid && (in_op == OP_TICK);
      end
      ST_SCAN: begin
        cmd.step = step_ok;
      end
      ST_FLUSH: begin
        cmd.flush = flush_ok;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/ptd_datapath.sv]
// slot tables, scan pointer and output register for the task dispatcher
`default_nettype none

module ptd_datapath #(
  parameter int NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ptd_pkg::ptd_cmd_t           cmd,
  input  wire logic [ptd_pkg::SLOT_W-1:0]  in_slot,
  input  wire logic [ptd_pkg::TIME_W-1:0]  in_period,
  input  wire logic [ptd_pkg::TIME_W-1:0]  in_start_delay,
  input  wire logic                        out_ready,
  output ptd_pkg::ptd_status_t             status,
  output logic                             out_valid,
  output logic [ptd_pkg::SLOT_W-1:0]       out_slot,
  output logic                             out_last
);

  import ptd_pkg::*;

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  logic              slot_valid     [NUM_TASKS];
  logic [TIME_W-1:0] slot_period    [NUM_TASKS];
  logic [TIME_W-1:0] slot_countdown [NUM_TASKS];

  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       held_idx;
  logic                   held_valid;
  logic [IDX_W+SLOT_W-1:0] slot_wide;
  logic [IDX_W+SLOT_W-1:0] held_wide;
  logic [IDX_W-1:0]       wr_idx;
  logic                   wr_in_range;
  logic                   cur_valid;
  logic [TIME_W-1:0]      cur_count;
  logic [TIME_W-1:0]      cur_period;
  logic                   due;
  logic                   out_free;
  logic                   load_mid;
  logic                   load_end;

  // create address and its range check
  assign slot_wide   = (IDX_W+SLOT_W)'(in_slot);
  assign wr_idx      = slot_wide[IDX_W-1:0];
  assign wr_in_range = (32'(in_slot) < NUM_TASKS);
  assign held_wide   = (IDX_W+SLOT_W)'(held_idx);

  // current slot under the scan pointer
  assign cur_valid  = slot_valid[scan_idx];
  assign cur_count  = slot_countdown[scan_idx];
  assign cur_period = slot_period[scan_idx];
  assign due        = cur_valid && (cur_count == '0);

  assign out_free = !out_valid || out_ready;
  assign load_mid = cmd.step && due && held_valid;
  assign load_end = cmd.flush && held_valid;

  assign status.due        = due;
  assign status.held_valid = held_valid;
  assign status.out_free   = out_free;
  assign status.scan_end   = (scan_idx == IDX_W'(NUM_TASKS - 1));

  // control state: valid marks, scan pointer, held and output flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        slot_valid[i] <= 1'b0;
      end
      scan_idx   <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // a new word loads, otherwise a taken word clears the flag
      if (load_mid || load_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.create && wr_in_range) begin
        slot_valid[wr_idx] <= 1'b1;
      end
      if (cmd.scan_clear) begin
        scan_idx   <= '0;
        held_valid <= 1'b0;
      end
      if (cmd.step) begin
        scan_idx <= scan_idx + IDX_W'(1);
        if (due) begin
          held_valid <= 1'b1;
        end
      end
      if (cmd.flush) begin
        held_valid <= 1'b0;
      end
    end
  end

  // slot tables and payload registers
  always_ff @(posedge clk) begin
    if (cmd.create && wr_in_range) begin
      slot_period[wr_idx]    <= in_period;
      slot_countdown[wr_idx] <= in_start_delay;
    end
    if (cmd.step && cur_valid) begin
      if (due) begin
        slot_countdown[scan_idx] <= cur_period - TIME_W'(1);
        held_idx                 <= scan_idx;
      end else begin
        slot_countdown[scan_idx] <= cur_count - TIME_W'(1);
      end
    end
    if (load_mid || load_end) begin
      out_slot <= held_wide[SLOT_W-1:0];
      out_last <= load_end;
    end
  end

  // a word is never written over one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    (load_mid || load_end) |-> out_free)
    else $error("output word overwritten while stalled");

  // a held slot followed by another due slot goes out as not last
  assert property (@(posedge clk) disable iff (rst)
    load_mid |=> (out_valid && !out_last))
    else $error("mid-run word missing or marked last");

  // the flush hands out the held slot as the last word
  assert property (@(posedge clk) disable iff (rst)
    load_end |=> (out_valid && out_last && !held_valid))
    else $error("final word missing or not marked last");

  // a new scan starts with nothing held
  assert property (@(posedge clk) disable iff (rst)
    cmd.scan_clear |=> (!held_valid && (scan_idx == '0)))
    else $error("scan did not start clean");

endmodule

`default_nettype wire

[verif/periodic_task_dispatcher_core_tb.sv]
// testbench for the periodic task dispatcher: directed and random words, self-checking
`default_nettype none

module periodic_task_dispatcher_core_tb;
  import ptd_pkg::*;

  localparam int NUM_TASKS = NUM_TASKS_DEF;
  localparam int LIMIT_CYCLES = 200000;

  // one input word as queued for the driver
  typedef struct {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] start_delay;
    bit                drain_first;  // hold off until every due word has come back
  } sched_word_t;

  // one due-task word as seen on the output
  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } due_word_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = OP_TICK;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // predicted task table
  bit                task_live   [NUM_TASKS];
  logic [TIME_W-1:0] task_period [NUM_TASKS];
  logic [TIME_W-1:0] task_count  [NUM_TASKS];

  sched_word_t pend_q[$];
  due_word_t   due_q[$];
  sched_word_t cur_word;

  int n_sent = 0;
  int n_ticks = 0;
  int n_creates = 0;
  int n_words = 0;
  int n_full_ticks = 0;
  int errors = 0;

  periodic_task_dispatcher_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // apply one accepted word to the predicted table and queue the due tasks it yields
  function automatic void dispatch_step(input sched_word_t w);
    int        hits;
    due_word_t d;
    hits = 0;
    if (w.op == OP_CREATE) begin
      n_creates++;
      if (int'(w.slot) < NUM_TASKS) begin
        task_period[w.slot] = w.period;
        task_count[w.slot]  = w.start_delay;
        task_live[w.slot]   = 1'b1;
      end
    end else begin
      n_ticks++;
      // scan in priority order, lowest index first
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (task_live[i]) begin
          if (task_count[i] == '0) begin
            d.slot = SLOT_W'(i);
            d.last = 1'b0;
            due_q.push_back(d);
            hits++;
            task_count[i] = task_period[i] - 16'd1;
          end else begin
            task_count[i] = task_count[i] - 16'd1;
          end
        end
      end
      // mark the final due task of this tick
      if (hits > 0) begin
        d = due_q.pop_back();
        d.last = 1'b1;
        due_q.push_back(d);
      end
      if (hits == NUM_TASKS) n_full_ticks++;
    end
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic add_create(input int slot, input int per, input int dly, input bit drain);
    sched_word_t w;
    w.op          = OP_CREATE;
    w.slot        = SLOT_W'(slot);
    w.period      = TIME_W'(per);
    w.start_delay = TIME_W'(dly);
    w.drain_first = drain;
    pend_q.push_back(w);
  endtask

  // period and delay are noise on a tick
  task automatic add_tick(input bit drain);
    sched_word_t w;
    w.op          = OP_TICK;
    w.slot        = SLOT_W'($urandom_range(7));
    w.period      = TIME_W'($urandom);
    w.start_delay = TIME_W'($urandom);
    w.drain_first = drain;
    pend_q.push_back(w);
  endtask

  function automatic int pick_time();
    if ($urandom_range(99) < 75) pick_time = $urandom_range(6);
    else pick_time = $urandom_range(65535);
  endfunction

  // driver: presents queued words, idles at random outside a calm stretch
  always @(posedge clk) begin
    bit fire;
    bit gap;
    fire = s_axis_tvalid && s_axis_tready;
    gap = ($urandom_range(99) < 17) && !(n_sent >= 70 && n_sent < 110);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        dispatch_step(cur_word);
        n_sent++;
      end
      if (!s_axis_tvalid || fire) begin
        if (pend_q.size() != 0 && !gap &&
            !(pend_q[0].drain_first && due_q.size() != 0)) begin
          cur_word = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_word.op;
          s_axis_tdata  <= {5'b0, cur_word.start_delay, cur_word.period, cur_word.slot};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: stalls at random, checks each word against the oldest prediction
  always @(posedge clk) begin
    due_word_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_words++;
        if (due_q.size() == 0) begin
          note_error($sformatf("unexpected word slot=%0d last=%0b",
                               m_axis_tdata[SLOT_W-1:0], m_axis_tlast));
        end else begin
          want = due_q.pop_front();
          if (m_axis_tdata[SLOT_W-1:0] !== want.slot)
            note_error($sformatf("due_slot expected %0d got %0d",
                                 want.slot, m_axis_tdata[SLOT_W-1:0]));
          if (m_axis_tlast !== want.last)
            note_error($sformatf("last expected %0b got %0b (slot %0d)",
                                 want.last, m_axis_tlast, want.slot));
        end
      end
      m_axis_tready <= !(($urandom_range(99) < 17) && !(n_words >= 40 && n_words < 80));
    end
  end

  // stimulus, reset and end of run
  initial begin
    int wait_n;
    for (int i = 0; i < NUM_TASKS; i++) begin
      task_live[i]   = 1'b0;
      task_period[i] = '0;
      task_count[i]  = '0;
    end

    // directed: empty table, extremes, zero period, overwrite, every slot due at once
    add_tick(1'b0);
    add_create(0, 1, 0, 1'b0);
    add_create(7, 0, 0, 1'b0);
    add_create(3, 65535, 65535, 1'b0);
    add_create(5, 2, 1, 1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    for (int s = 0; s < 8; s++) add_create(s, 1, 0, 1'b0);
    add_tick(1'b1);
    add_tick(1'b0);
    add_create(2, 3, 0, 1'b0);
    add_tick(1'b1);
    add_create(6, 65535, 0, 1'b0);
    add_tick(1'b0);

    // random: mostly short periods so tasks keep firing, some wide values
    for (int k = 0; k < 128; k++) begin
      if ($urandom_range(99) < 30)
        add_create($urandom_range(7), pick_time(), pick_time(), 1'b0);
      else
        add_tick($urandom_range(99) < 4);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    wait_n = 0;
    while (due_q.size() != 0 && wait_n < 5000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (4 * NUM_TASKS + 20) @(posedge clk);

    if (due_q.size() != 0) note_error($sformatf("%0d due words never came", due_q.size()));
    if (errors > 10) $display("%0d further mismatches not shown", errors - 10);

    $display("sent %0d words: %0d ticks and %0d task writes", n_sent, n_ticks, n_creates);
    $display("checked %0d due-task words, %0d ticks with every slot due, %0d errors",
             n_words, n_full_ticks, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20 * LIMIT_CYCLES);
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
